### sv/interval_union_merger_unit_assert.svh
// Assertion macros for the interval union merger unit.
// Used by the top level only; expects clk and rst_n in scope.
`ifndef INTERVAL_UNION_MERGER_UNIT_ASSERT_SVH
`define INTERVAL_UNION_MERGER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// Condition holds at every clock edge out of reset.
`define IUMU_ASSERT_HOLDS(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("iumu: invariant violated");

// Consequent holds in the same cycle as the antecedent.
`define IUMU_ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("iumu: same-cycle implication violated");

// Consequent holds in the cycle after the antecedent.
`define IUMU_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("iumu: next-cycle implication violated");

`else

`define IUMU_ASSERT_HOLDS(label, cond)
`define IUMU_ASSERT_IMPLIES(label, ante, cons)
`define IUMU_ASSERT_NEXT(label, ante, cons)

`endif

`endif

### sv/iumu_pkg.sv
// Shared types and constants of the interval union merger unit.
// No dependencies; every other RTL file imports this package.
`default_nettype none

package iumu_pkg;

    localparam int MAX_INTERVALS = 32;
    localparam int DATA_W        = 16;
    localparam int CNT_W         = $clog2(MAX_INTERVALS + 1);
    localparam int IDX_W         = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1;
    localparam int OPEN_W        = CNT_W + 1;

    // Small queues between the parts (depth is a power of two).
    localparam int Q_DEPTH  = 2;
    localparam int Q_PTR_W  = 1;
    localparam int Q_CNT_W  = 2;

    typedef struct packed {
        logic signed [DATA_W-1:0] interval_start;
        logic signed [DATA_W-1:0] interval_end;
        logic                     last_interval;
    } in_item_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] union_lo;
        logic signed [DATA_W-1:0] union_hi;
        logic                     last_merged;
        logic                     overflowed;
    } res_item_t;

    // Classified item handed from front to back.
    typedef struct packed {
        in_item_t item;
        logic     keep;
    } q_item_t;

    typedef struct packed {
        logic             sweeping;
        logic [CNT_W-1:0] count;
    } back_stat_t;

    typedef enum logic [1:0] {
        ST_LOAD  = 2'b01,
        ST_SWEEP = 2'b10
    } back_state_t;

endpackage

`default_nettype wire

### sv/iumu_front.sv
// Front part: accepts items, marks those past capacity as dropped, queues them.
// Depends on iumu_pkg.
`default_nettype none

module iumu_front (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    output logic                    full,
    input  wire iumu_pkg::in_item_t item,
    output logic                    q_valid,
    input  wire logic               q_pop,
    output iumu_pkg::q_item_t       q_data
);
    import iumu_pkg::*;

    logic [CNT_W-1:0]   count_reg, count_next;
    q_item_t            q_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [Q_CNT_W-1:0] fill_reg, fill_next;
    logic               accept;
    logic               keep;

    assign full    = (fill_reg == Q_CNT_W'(Q_DEPTH));
    assign q_valid = (fill_reg != '0);
    assign q_data  = q_mem[rd_ptr_reg];
    assign accept  = push && !full;
    assign keep    = (count_reg < CNT_W'(MAX_INTERVALS));

    always_comb
    begin
        count_next = count_reg;
        if (accept)
        begin
            if (item.last_interval)
                count_next = '0;
            else if (keep)
                count_next = count_reg + CNT_W'(1);
        end
        fill_next = fill_reg + Q_CNT_W'(accept) - Q_CNT_W'(q_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            fill_reg   <= '0;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
            fill_reg  <= fill_next;
            if (accept)
                wr_ptr_reg <= wr_ptr_reg + Q_PTR_W'(1);
            if (q_pop)
                rd_ptr_reg <= rd_ptr_reg + Q_PTR_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            q_mem[wr_ptr_reg] <= '{item: item, keep: keep};
    end

endmodule

`default_nettype wire

### sv/iumu_sort_list.sv
// One sorted list of keys: a row of compare-and-shift cells, one insert a cycle.
// Depends on iumu_pkg.
`default_nettype none

module iumu_sort_list (
    input  wire logic                                    clk,
    input  wire logic                                    insert,
    input  wire logic signed [iumu_pkg::DATA_W-1:0]      key,
    input  wire logic        [iumu_pkg::CNT_W-1:0]       count,
    input  wire logic        [iumu_pkg::IDX_W-1:0]       rd_idx,
    output logic signed      [iumu_pkg::DATA_W-1:0]      rd_data
);
    import iumu_pkg::*;

    logic signed [DATA_W-1:0] list_reg  [MAX_INTERVALS];
    logic signed [DATA_W-1:0] list_next [MAX_INTERVALS];
    logic signed [DATA_W-1:0] list_up   [MAX_INTERVALS];
    logic [MAX_INTERVALS-1:0] gt;
    logic [MAX_INTERVALS-1:0] gt_prev;

    assign rd_data = list_reg[rd_idx];

    always_comb
    begin
        // Each cell compares its entry with the new key.
        for (int i = 0; i < MAX_INTERVALS; i++)
            gt[i] = (CNT_W'(i) < count) && (list_reg[i] > key);
        gt_prev = gt << 1;

        list_up[0] = key;
        for (int i = 1; i < MAX_INTERVALS; i++)
            list_up[i] = list_reg[i-1];

        // Cells above the key shift up by one; the first of them takes the key.
        for (int i = 0; i < MAX_INTERVALS; i++)
        begin
            list_next[i] = list_reg[i];
            if (gt[i] || (CNT_W'(i) == count))
                list_next[i] = gt_prev[i] ? list_up[i] : key;
        end
    end

    always_ff @(posedge clk)
    begin
        if (insert)
            list_reg <= list_next;
    end

endmodule

`default_nettype wire

### sv/iumu_back.sv
// Back part: loads sorted lists, sweeps them with an open count, queues results.
// Depends on iumu_pkg and iumu_sort_list.
`default_nettype none

module iumu_back (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                q_valid,
    output logic                     q_pop,
    input  wire iumu_pkg::q_item_t   q_data,
    output logic                     empty,
    input  wire logic                pop,
    output iumu_pkg::res_item_t      result,
    output iumu_pkg::back_stat_t     stat
);
    import iumu_pkg::*;

    back_state_t              state_reg, state_next;
    logic [CNT_W-1:0]         count_reg, count_next;
    logic                     ovf_reg, ovf_next;
    logic [CNT_W-1:0]         s_reg, s_next;
    logic [CNT_W-1:0]         e_reg, e_next;
    logic signed [OPEN_W-1:0] open_reg, open_next;
    logic signed [DATA_W-1:0] open_start_reg, open_start_next;
    logic                     pend_valid_reg, pend_valid_next;
    logic signed [DATA_W-1:0] pend_start_reg, pend_start_next;
    logic signed [DATA_W-1:0] pend_end_reg, pend_end_next;

    res_item_t                rq_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0]       rq_wr_reg, rq_rd_reg;
    logic [Q_CNT_W-1:0]       rq_fill_reg;
    logic                     rq_full;
    logic                     rq_push;
    logic                     rq_pop;
    res_item_t                rq_in;

    logic                     insert;
    logic signed [DATA_W-1:0] s_rd, e_rd;
    logic                     s_left, e_left, take_start;

    assign insert = q_pop && q_data.keep;

    iumu_sort_list u_start_list (
        .clk     (clk),
        .insert  (insert),
        .key     (q_data.item.interval_start),
        .count   (count_reg),
        .rd_idx  (s_reg[IDX_W-1:0]),
        .rd_data (s_rd)
    );

    iumu_sort_list u_end_list (
        .clk     (clk),
        .insert  (insert),
        .key     (q_data.item.interval_end),
        .count   (count_reg),
        .rd_idx  (e_reg[IDX_W-1:0]),
        .rd_data (e_rd)
    );

    assign rq_full = (rq_fill_reg == Q_CNT_W'(Q_DEPTH));
    assign empty   = (rq_fill_reg == '0);
    assign rq_pop  = pop && !empty;
    assign result  = rq_mem[rq_rd_reg];

    assign s_left     = (s_reg < count_reg);
    assign e_left     = (e_reg < count_reg);
    assign take_start = s_left && (!e_left || (s_rd < e_rd));

    assign q_pop = (state_reg == ST_LOAD) && q_valid;

    assign stat.sweeping = (state_reg == ST_SWEEP);
    assign stat.count    = count_reg;

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        ovf_next        = ovf_reg;
        s_next          = s_reg;
        e_next          = e_reg;
        open_next       = open_reg;
        open_start_next = open_start_reg;
        pend_valid_next = pend_valid_reg;
        pend_start_next = pend_start_reg;
        pend_end_next   = pend_end_reg;
        rq_push         = 1'b0;
        rq_in           = '{union_lo: pend_start_reg, union_hi: pend_end_reg,
                            last_merged: 1'b0, overflowed: ovf_reg};

        unique case (state_reg)
            ST_LOAD:
            begin
                if (q_pop)
                begin
                    if (q_data.keep)
                        count_next = count_reg + CNT_W'(1);
                    else
                        ovf_next = 1'b1;
                    if (q_data.item.last_interval)
                    begin
                        state_next      = ST_SWEEP;
                        s_next          = '0;
                        e_next          = '0;
                        open_next       = '0;
                        pend_valid_next = 1'b0;
                    end
                end
            end
            ST_SWEEP:
            begin
                // Advance only with room for a result, so a closing step never stalls.
                if (!rq_full)
                begin
                    if (s_left || e_left)
                    begin
                        if (take_start)
                        begin
                            open_next = open_reg + OPEN_W'(1);
                            if (open_reg == '0)
                                open_start_next = s_rd;
                            s_next = s_reg + CNT_W'(1);
                        end
                        else
                        begin
                            open_next = open_reg - OPEN_W'(1);
                            if (open_reg == OPEN_W'(1))
                            begin
                                rq_push         = pend_valid_reg;
                                pend_valid_next = 1'b1;
                                pend_start_next = open_start_reg;
                                pend_end_next   = e_rd;
                            end
                            e_next = e_reg + CNT_W'(1);
                        end
                    end
                    else
                    begin
                        // Flush the held interval as the last one and drop the set.
                        rq_push           = pend_valid_reg;
                        rq_in.last_merged = 1'b1;
                        pend_valid_next   = 1'b0;
                        count_next        = '0;
                        ovf_next          = 1'b0;
                        state_next        = ST_LOAD;
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_LOAD;
            count_reg      <= '0;
            ovf_reg        <= 1'b0;
            s_reg          <= '0;
            e_reg          <= '0;
            open_reg       <= '0;
            pend_valid_reg <= 1'b0;
            rq_wr_reg      <= '0;
            rq_rd_reg      <= '0;
            rq_fill_reg    <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            ovf_reg        <= ovf_next;
            s_reg          <= s_next;
            e_reg          <= e_next;
            open_reg       <= open_next;
            pend_valid_reg <= pend_valid_next;
            rq_fill_reg    <= rq_fill_reg + Q_CNT_W'(rq_push) - Q_CNT_W'(rq_pop);
            if (rq_push)
                rq_wr_reg <= rq_wr_reg + Q_PTR_W'(1);
            if (rq_pop)
                rq_rd_reg <= rq_rd_reg + Q_PTR_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        open_start_reg <= open_start_next;
        pend_start_reg <= pend_start_next;
        pend_end_reg   <= pend_end_next;
        if (rq_push)
            rq_mem[rq_wr_reg] <= rq_in;
    end

endmodule

`default_nettype wire

### sv/interval_union_merger_unit.sv
// Interval union merger: top level joining the front queue and the sorting/sweep back end.
// Loading: one interval per cycle while the front queue has room and no sweep runs; each beat
// passes through the front queue into the lists. Merge: after the last beat, the starts and ends
// are swept in order, pausing while the result queue is full; a merged interval is held until
// the next one closes or the sweep ends. The single sweep step per cycle sets the throughput.
// Reset (rst_n, asynchronous, active low) empties both queues and the set; no clearing pass.
`default_nettype none

`include "interval_union_merger_unit_assert.svh"

module interval_union_merger_unit (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    output logic                      full,
    input  wire iumu_pkg::in_item_t   item,
    output logic                      empty,
    input  wire logic                 pop,
    output iumu_pkg::res_item_t       result
);
    import iumu_pkg::*;

    // Classified beats travel from front to back through a two-entry queue.
    logic       q_valid;
    logic       q_pop;
    q_item_t    q_data;
    back_stat_t back_stat;

    // Front: take beats, count the set and mark any beat past capacity for dropping.
    iumu_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .item    (item),
        .q_valid (q_valid),
        .q_pop   (q_pop),
        .q_data  (q_data)
    );

    // Back: insert starts and ends into their sorted lists, then on the last beat
    // sweep both lists and hold each merged interval until the next one proves
    // whether it is the final one of the set.
    iumu_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_pop   (q_pop),
        .q_data  (q_data),
        .empty   (empty),
        .pop     (pop),
        .result  (result),
        .stat    (back_stat)
    );

    // The back never draws from an empty queue.
    `IUMU_ASSERT_IMPLIES(a_pop_needs_beat, q_pop, q_valid)
    // No beat is loaded while a sweep is running.
    `IUMU_ASSERT_IMPLIES(a_hold_during_sweep, back_stat.sweeping, !q_pop)
    // The stored set never grows past capacity.
    `IUMU_ASSERT_HOLDS(a_count_bounded, back_stat.count <= CNT_W'(MAX_INTERVALS))
    // Loading the last beat of a set starts the sweep.
    `IUMU_ASSERT_NEXT(a_last_starts_sweep, q_pop && q_data.item.last_interval, back_stat.sweeping)

endmodule

`default_nettype wire

### bench/iumu_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the interval union merger unit: watches the load and result queues,
// rebuilds the union of every closed set and compares each result beat against it.
// Depends on iumu_pkg for the beat types and the store capacity.
module iumu_checker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  logic                full,
    input  iumu_pkg::in_item_t  item,
    input  logic                empty,
    input  logic                pop,
    input  iumu_pkg::res_item_t result,
    output int                  fail_count,
    output int                  pending
);

    localparam int RESULT_CAP = 32;

    logic signed [15:0]  start_list [iumu_pkg::MAX_INTERVALS];
    logic signed [15:0]  end_list   [iumu_pkg::MAX_INTERVALS];
    int                  held       = 0;
    bit                  dropped    = 1'b0;
    int                  errors     = 0;
    int                  waiting    = 0;
    iumu_pkg::res_item_t merged_due [$];
    iumu_pkg::res_item_t due;

    assign fail_count = errors;
    assign pending    = waiting;

    // Sort starts and ends apart, then sweep them with a count of open intervals.
    function automatic void merge_set();
        int                  lists [2][iumu_pkg::MAX_INTERVALS];
        iumu_pkg::res_item_t found [$];
        iumu_pkg::res_item_t r;
        int                  n, s, e, depth, opened, key, j;
        bit                  lost;
        n      = held;
        lost   = dropped;
        s      = 0;
        e      = 0;
        depth  = 0;
        opened = 0;
        for (int k = 0; k < n; k++)
        begin
            lists[0][k] = start_list[k];
            lists[1][k] = end_list[k];
        end
        for (int w = 0; w < 2; w++)
        begin
            for (int i = 1; i < n; i++)
            begin
                key = lists[w][i];
                j   = i;
                while (j > 0 && lists[w][j - 1] > key)
                begin
                    lists[w][j] = lists[w][j - 1];
                    j--;
                end
                lists[w][j] = key;
            end
        end
        while (s < n || e < n)
        begin
            // A start wins only when strictly below the end: touching intervals stay apart.
            if (s < n && (e >= n || lists[0][s] < lists[1][e]))
            begin
                depth++;
                if (depth == 1)
                    opened = lists[0][s];
                s++;
            end
            else
            begin
                depth--;
                if (depth == 0)
                begin
                    if (found.size() < RESULT_CAP)
                    begin
                        r.union_lo    = opened[15:0];
                        r.union_hi    = lists[1][e][15:0];
                        r.last_merged = 1'b0;
                        r.overflowed  = 1'b0;
                        found         = {found, r};
                    end
                    else
                        lost = 1'b1;
                end
                e++;
            end
        end
        for (int i = 0; i < found.size(); i++)
        begin
            r             = found[i];
            r.overflowed  = lost;
            r.last_merged = (i == found.size() - 1);
            merged_due    = {merged_due, r};
        end
    endfunction

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pop && !empty)
            begin
                if (merged_due.size() == 0)
                begin
                    $display("%0t: unexpected result start %0d end %0d last %b ovf %b",
                             $time, result.union_lo, result.union_hi,
                             result.last_merged, result.overflowed);
                    errors++;
                end
                else
                begin
                    due = merged_due.pop_front();
                    if (result.union_lo    !== due.union_lo    ||
                        result.union_hi    !== due.union_hi    ||
                        result.last_merged !== due.last_merged ||
                        result.overflowed  !== due.overflowed)
                    begin
                        $display("%0t: expected %0d..%0d l%b o%b, got %0d..%0d l%b o%b",
                                 $time, due.union_lo, due.union_hi, due.last_merged,
                                 due.overflowed, result.union_lo, result.union_hi,
                                 result.last_merged, result.overflowed);
                        errors++;
                    end
                end
            end
            if (push && !full)
            begin
                if (held < iumu_pkg::MAX_INTERVALS)
                begin
                    start_list[held] = item.interval_start;
                    end_list[held]   = item.interval_end;
                    held++;
                end
                else
                    dropped = 1'b1;
                if (item.last_interval)
                begin
                    merge_set();
                    held    = 0;
                    dropped = 1'b0;
                end
            end
            waiting = merged_due.size();
        end
    end

endmodule

### bench/tb_top.sv
`timescale 1ns / 1ps
// Top of the interval union merger unit bench: clock, reset, load and drain traffic, verdict.
// Depends on iumu_pkg, interval_union_merger_unit and iumu_checker.
module tb_top;

    // Cycles without any accepted beat before the run is declared hung. The slowest
    // legal stretch is the long drain hold plus a full 32-interval sweep, well under this.
    localparam int STALL_LIMIT = 4000;
    // Long receiver hold used to fill the block and back-pressure the loader.
    localparam int LONG_HOLD   = 300;
    // Quiet tail after the last result, longer than a full 32-interval sweep.
    localparam int TAIL_CYCLES = 150;
    localparam int RANDOM_BEATS = 200;

    logic                clk    = 1'b0;
    logic                rst_n  = 1'b0;
    logic                push   = 1'b0;
    logic                pop    = 1'b0;
    iumu_pkg::in_item_t  item   = '0;
    logic                full;
    logic                empty;
    iumu_pkg::res_item_t result;
    int                  fail_count;
    int                  pending;
    int                  idle_cycles = 0;
    // calm: no idling on either side; hold_req: ask the drain side for its long hold.
    bit                  calm     = 1'b0;
    bit                  hold_req = 1'b0;

    interval_union_merger_unit dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .item   (item),
        .empty  (empty),
        .pop    (pop),
        .result (result)
    );

    iumu_checker u_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .item       (item),
        .empty      (empty),
        .pop        (pop),
        .result     (result),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // Offer one interval beat and hold it until the block takes it. Push stays high
    // afterwards so that the next beat can follow back to back; an idle burst drops it first.
    task automatic offer(input int lo, input int hi, input bit fin);
        iumu_pkg::in_item_t beat;
        int                 gap;
        gap = 0;
        if (!calm && $urandom_range(0, 4) == 0)
            gap = $urandom_range(1, 5);
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        beat.interval_start = lo[15:0];
        beat.interval_end   = hi[15:0];
        beat.last_interval  = fin;
        push <= 1'b1;
        item <= beat;
        do
            @(posedge clk);
        while (full);
    endtask

    // Drop push and wait until every predicted result has been drained. The first edge
    // lets the scoreboard register a set closed by the beat just taken.
    task automatic settle();
        push <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    // One random set: all beats drawn from a window whose width decides how often
    // intervals overlap or touch. Most come well ordered; one in ten of those drawn inverted stays so.
    task automatic random_set(input int len);
        int mode, span, base, lo, hi, t;
        mode = $urandom_range(0, 2);
        span = (mode == 0) ? 65535 : (mode == 1) ? 2000 : 60;
        base = int'($urandom_range(0, 65535 - span)) - 32768;
        for (int k = 0; k < len; k++)
        begin
            lo = base + int'($urandom_range(0, span));
            hi = base + int'($urandom_range(0, span));
            if (lo > hi && $urandom_range(0, 9) != 0)
            begin
                t  = lo;
                lo = hi;
                hi = t;
            end
            offer(lo, hi, k == len - 1);
        end
    endtask

    // Load side: reset, directed sets, then random sets until enough beats have gone in.
    initial
    begin
        int  loaded;
        int  len;
        bit  held_once;
        loaded    = 0;
        held_once = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Full-range single interval.
        offer(-32768, 32767, 1'b1);
        // Touching intervals stay apart.
        offer(0, 100, 1'b0);
        offer(100, 200, 1'b1);
        settle();
        // Nested and chained overlaps fold into one.
        offer(10, 50, 1'b0);
        offer(20, 30, 1'b0);
        offer(40, 80, 1'b1);
        // Point interval vanishes: empty union, no results.
        offer(5, 5, 1'b1);
        // Inverted interval beside a normal one.
        offer(100, -100, 1'b0);
        offer(200, 300, 1'b1);
        // Inverted extremes, then points at both extremes: both empty.
        offer(32767, -32768, 1'b1);
        offer(-32768, -32768, 1'b0);
        offer(32767, 32767, 1'b1);
        // Out-of-order loads merging across zero.
        offer(-5, 5, 1'b0);
        offer(-10, -1, 1'b0);
        offer(3, 20, 1'b1);
        settle();

        // Random sets: mostly small, now and then past the store capacity so that beats
        // (the closing one included) get dropped.
        while (loaded < RANDOM_BEATS)
        begin
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 36) : $urandom_range(1, 8);
            if (!held_once && loaded >= 60)
            begin
                // Stall the drain side and keep loading so that the block backs up.
                hold_req  = 1'b1;
                held_once = 1'b1;
                len       = 24;
            end
            if (loaded >= RANDOM_BEATS - 30)
                calm = 1'b1;
            random_set(len);
            loaded += len;
            // Keep loading through the long hold so that the input really stalls.
            if (!hold_req && $urandom_range(0, 5) == 0)
                settle();
        end

        settle();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("interval_union_merger_unit verification clean");
        else
            $display("interval_union_merger_unit verification failed");
        $finish;
    end

    // Drain side: pop with random idle bursts, one long hold on request, none once calm.
    initial
    begin
        int gap;
        wait (rst_n === 1'b1);
        forever
        begin
            if (hold_req)
            begin
                pop <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                hold_req = 1'b0;
            end
            else if (!calm && $urandom_range(0, 5) == 0)
            begin
                pop <= 1'b0;
                gap = $urandom_range(1, 5);
                repeat (gap) @(posedge clk);
            end
            else
            begin
                pop <= 1'b1;
                @(posedge clk);
            end
        end
    end

    // Watchdog: count cycles with no accepted beat on either side.
    always @(posedge clk)
    begin
        if (!rst_n || (push && !full) || (pop && !empty))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("interval_union_merger_unit verification failed");
            $finish;
        end
    end

endmodule

### files.f
+incdir+sv
sv/iumu_pkg.sv
sv/iumu_front.sv
sv/iumu_sort_list.sv
sv/iumu_back.sv
sv/interval_union_merger_unit.sv
bench/iumu_checker.sv
bench/tb_top.sv
